>>> hdl/ferp_pkg.sv
// Package: item types, format codes and field positions for the exponent range profiler.
`default_nettype none
package ferp_pkg;

    localparam int SITES  = 256;
    localparam int SITE_W = 8;
    localparam int EXP_W  = 11;
    localparam int RAW_W  = 64;

    localparam logic [1:0] FMT_BAD    = 2'd0;
    localparam logic [1:0] FMT_HALF   = 2'd1;
    localparam logic [1:0] FMT_SINGLE = 2'd2;
    localparam logic [1:0] FMT_DOUBLE = 2'd3;

    localparam int HALF_EXP_LSB   = 10;
    localparam int HALF_EXP_W     = 5;
    localparam int HALF_SIGN      = 15;
    localparam int SINGLE_EXP_LSB = 23;
    localparam int SINGLE_EXP_W   = 8;
    localparam int SINGLE_SIGN    = 31;
    localparam int DOUBLE_EXP_LSB = 52;
    localparam int DOUBLE_EXP_W   = 11;
    localparam int DOUBLE_SIGN    = 63;

    typedef struct packed {
        logic [1:0]        fmt;
        logic [SITE_W-1:0] site;
        logic [RAW_W-1:0]  raw_bits;
    } in_item_t;

    typedef struct packed {
        logic [SITE_W-1:0] site_echo;
        logic              seen;
        logic [EXP_W-1:0]  min_exp;
        logic [EXP_W-1:0]  max_exp;
        logic              neg_seen;
        logic              bad_format;
        logic              skipped;
    } out_item_t;

    // decoded sample, held between input stage and table update
    typedef struct packed {
        logic [SITE_W-1:0] site;
        logic [EXP_W-1:0]  expo;
        logic              neg;
        logic              bad;
        logic              skip;
    } samp_t;

    // one site's stored record
    typedef struct packed {
        logic             seen;
        logic [EXP_W-1:0] lo;
        logic [EXP_W-1:0] hi;
        logic             neg;
        logic             bad;
    } entry_t;

endpackage
`default_nettype wire

>>> hdl/float_exponent_range_profiler.sv
// Top level of the floating-point exponent range profiler.
// Input: start with sample (format code, site, raw bits); an item is taken
// at each rising edge with start high and busy low. busy stays low, so an
// item may be given in every cycle.
// Output: done is high for one cycle with the site's updated record on
// record; the receiver takes it in that cycle and cannot hold it off.
// Steps: the decoded value is registered and the record memory read at the
// edge that takes the item; then the site is updated, and the result register
// is loaded together with done.
// Throughput: one item per cycle; back-to-back items on the same site are
// served by forwarding the last write around the memory.
// Reset (rst_n low) clears the written mark of every site at once and drops
// any item in flight; the record memory is not cleared, and a site not
// written since reset reads as an empty record.
`default_nettype none
module float_exponent_range_profiler
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  ferp_pkg::in_item_t  sample,
    output logic                done,
    output ferp_pkg::out_item_t record
);
    import ferp_pkg::*;

    logic      take;
    samp_t     samp_next;
    samp_t     s_reg;
    logic      s_valid_reg;
    out_item_t rec_next;
    out_item_t record_reg;
    logic      done_reg;

    assign busy = 1'b0;
    assign take = start & ~busy;

    ferp_extract u_extract
    (
        .sample (sample),
        .samp   (samp_next)
    );

    ferp_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (take),
        .rd_site (sample.site),
        .s_valid (s_valid_reg),
        .s       (s_reg),
        .rec     (rec_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            s_valid_reg <= take;
            done_reg    <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s_reg <= samp_next;
        end
        if (s_valid_reg)
        begin
            record_reg <= rec_next;
        end
    end

    assign done   = done_reg;
    assign record = record_reg;

endmodule
`default_nettype wire

>>> hdl/ferp_extract.sv
// Format decode: biased exponent, sign and skip flags of one raw value.
`default_nettype none
module ferp_extract
(
    input  ferp_pkg::in_item_t sample,
    output ferp_pkg::samp_t    samp
);
    import ferp_pkg::*;

    logic [EXP_W-1:0] expo;
    logic             neg;
    logic             bad;

    always_comb
    begin
        expo = '0;
        neg  = 1'b0;
        bad  = 1'b0;
        unique case (sample.fmt)
            FMT_HALF:
            begin
                expo = EXP_W'(sample.raw_bits[HALF_EXP_LSB +: HALF_EXP_W]);
                neg  = sample.raw_bits[HALF_SIGN];
            end
            FMT_SINGLE:
            begin
                expo = EXP_W'(sample.raw_bits[SINGLE_EXP_LSB +: SINGLE_EXP_W]);
                neg  = sample.raw_bits[SINGLE_SIGN];
            end
            FMT_DOUBLE:
            begin
                expo = EXP_W'(sample.raw_bits[DOUBLE_EXP_LSB +: DOUBLE_EXP_W]);
                neg  = sample.raw_bits[DOUBLE_SIGN];
            end
            FMT_BAD:
            begin
                bad = 1'b1;
            end
        endcase
    end

    assign samp.site = sample.site;
    assign samp.expo = expo;
    assign samp.neg  = neg;
    assign samp.bad  = bad;
    assign samp.skip = bad | (expo == '0);

endmodule
`default_nettype wire

>>> hdl/ferp_table.sv
// Per-site record table: record memory, written marks, forwarding and update.
`default_nettype none
module ferp_table
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          rd_en,
    input  wire [ferp_pkg::SITE_W-1:0]   rd_site,
    input  wire                          s_valid,
    input  ferp_pkg::samp_t              s,
    output ferp_pkg::out_item_t          rec
);
    import ferp_pkg::*;

    entry_t           ent_mem [SITES];
    entry_t           rd_ent_reg;

    // set once a site's entry has been written since reset
    logic [SITES-1:0] written_reg;

    // last write, covers the read that shared its edge
    logic              lw_valid_reg;
    logic [SITE_W-1:0] lw_site_reg;
    entry_t            lw_ent_reg;

    entry_t cur;
    entry_t ent_next;
    logic   fwd;
    logic   wr_en;

    always_comb
    begin
        fwd      = lw_valid_reg && (lw_site_reg == s.site);
        wr_en    = s_valid;
        cur      = fwd ? lw_ent_reg : (written_reg[s.site] ? rd_ent_reg : '0);
        ent_next = cur;
        if (s.bad)
        begin
            ent_next.bad = 1'b1;
        end
        if (!s.skip)
        begin
            if (!cur.seen || (s.expo < cur.lo))
            begin
                ent_next.lo = s.expo;
            end
            if (!cur.seen || (s.expo > cur.hi))
            begin
                ent_next.hi = s.expo;
            end
            ent_next.seen = 1'b1;
            ent_next.neg  = cur.neg | s.neg;
        end
    end

    assign rec.site_echo  = s.site;
    assign rec.seen       = ent_next.seen;
    assign rec.min_exp    = ent_next.seen ? ent_next.lo : '0;
    assign rec.max_exp    = ent_next.seen ? ent_next.hi : '0;
    assign rec.neg_seen   = ent_next.neg;
    assign rec.bad_format = ent_next.bad;
    assign rec.skipped    = s.skip;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_ent_reg <= ent_mem[rd_site];
        end
        if (wr_en)
        begin
            ent_mem[s.site] <= ent_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            lw_valid_reg <= wr_en;
            if (wr_en)
            begin
                written_reg[s.site] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lw_site_reg <= s.site;
            lw_ent_reg  <= ent_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/ferp_checker.sv
// Port-level checks for the exponent range profiler, bound to the top level.
`default_nettype none
module ferp_checker
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire                 busy,
    input  ferp_pkg::in_item_t  sample,
    input  wire                 done,
    input  ferp_pkg::out_item_t record
);
    import ferp_pkg::*;

    a_two_cycle_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("item taken without a record two cycles later");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> ##1 !done)
        else $error("record without a matching item");

    a_site_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 (record.site_echo == $past(sample.site, 2)))
        else $error("record site differs from item site");

    a_recorded_implies_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !record.skipped) |-> (record.seen && record.min_exp <= record.max_exp))
        else $error("recorded sample left an inconsistent range");

    a_bad_fmt_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && sample.fmt == FMT_BAD) |=> ##1 (record.bad_format && record.skipped))
        else $error("unknown format not flagged");

endmodule

bind float_exponent_range_profiler ferp_checker u_ferp_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .sample (sample),
    .done   (done),
    .record (record)
);
`default_nettype wire

>>> sim/ferp_record_checker.sv
// Checker for the exponent range profiler: predicts each site record and compares it.
`timescale 1ns / 100ps
module ferp_record_checker
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire                 busy,
    input  ferp_pkg::in_item_t  sample,
    input  wire                 done,
    input  ferp_pkg::out_item_t record,
    output int                  errors,
    output int                  pending,
    output int                  checked,
    output int                  skipped_total
);
    import ferp_pkg::*;

    logic [EXP_W-1:0] min_tab [SITES];
    logic [EXP_W-1:0] max_tab [SITES];
    logic             seen_tab [SITES];
    logic             neg_tab [SITES];
    logic             badfmt_tab [SITES];

    out_item_t expected_records [$];
    out_item_t want;
    int        fail_count = 0;
    int        n_checked = 0;
    int        n_skipped = 0;

    // updates the site table and returns the record the block should give back
    function automatic out_item_t predict_record(input in_item_t s);
        out_item_t        r;
        logic [EXP_W-1:0] e;
        logic             neg;
        logic             skip;
        r = '0;
        e = '0;
        neg = 1'b0;
        skip = 1'b0;
        r.site_echo = s.site;
        case (s.fmt)
            FMT_HALF:
            begin
                e = EXP_W'(s.raw_bits[HALF_EXP_LSB +: HALF_EXP_W]);
                neg = s.raw_bits[HALF_SIGN];
            end
            FMT_SINGLE:
            begin
                e = EXP_W'(s.raw_bits[SINGLE_EXP_LSB +: SINGLE_EXP_W]);
                neg = s.raw_bits[SINGLE_SIGN];
            end
            FMT_DOUBLE:
            begin
                e = EXP_W'(s.raw_bits[DOUBLE_EXP_LSB +: DOUBLE_EXP_W]);
                neg = s.raw_bits[DOUBLE_SIGN];
            end
            default:
            begin
                badfmt_tab[s.site] = 1'b1;
                skip = 1'b1;
            end
        endcase
        if (!skip && e == '0)
            skip = 1'b1;
        if (!skip)
        begin
            if (!seen_tab[s.site])
            begin
                min_tab[s.site] = e;
                max_tab[s.site] = e;
                seen_tab[s.site] = 1'b1;
            end
            else
            begin
                if (e < min_tab[s.site])
                    min_tab[s.site] = e;
                if (e > max_tab[s.site])
                    max_tab[s.site] = e;
            end
            neg_tab[s.site] = neg_tab[s.site] | neg;
        end
        r.seen = seen_tab[s.site];
        r.min_exp = seen_tab[s.site] ? min_tab[s.site] : '0;
        r.max_exp = seen_tab[s.site] ? max_tab[s.site] : '0;
        r.neg_seen = neg_tab[s.site];
        r.bad_format = badfmt_tab[s.site];
        r.skipped = skip;
        return r;
    endfunction

    task automatic report_mismatch(input string note);
        $display("[%0t] record %0d: %s", $realtime, n_checked, note);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_records.delete();
            for (int i = 0; i < SITES; i++)
            begin
                seen_tab[i] = 1'b0;
                neg_tab[i] = 1'b0;
                badfmt_tab[i] = 1'b0;
            end
            pending <= 0;
            errors <= 0;
            checked <= 0;
            skipped_total <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_records.size() == 0)
                    report_mismatch($sformatf("unexpected record for site %0d",
                                              record.site_echo));
                else
                begin
                    want = expected_records.pop_front();
                    if (record.site_echo !== want.site_echo)
                        report_mismatch($sformatf("site_echo %0d, want %0d",
                                                  record.site_echo, want.site_echo));
                    if (record.seen !== want.seen)
                        report_mismatch($sformatf("site %0d seen %b, want %b",
                                                  want.site_echo, record.seen, want.seen));
                    if (record.min_exp !== want.min_exp)
                        report_mismatch($sformatf("site %0d min_exp %0d, want %0d",
                                                  want.site_echo, record.min_exp,
                                                  want.min_exp));
                    if (record.max_exp !== want.max_exp)
                        report_mismatch($sformatf("site %0d max_exp %0d, want %0d",
                                                  want.site_echo, record.max_exp,
                                                  want.max_exp));
                    if (record.neg_seen !== want.neg_seen)
                        report_mismatch($sformatf("site %0d neg_seen %b, want %b",
                                                  want.site_echo, record.neg_seen,
                                                  want.neg_seen));
                    if (record.bad_format !== want.bad_format)
                        report_mismatch($sformatf("site %0d bad_format %b, want %b",
                                                  want.site_echo, record.bad_format,
                                                  want.bad_format));
                    if (record.skipped !== want.skipped)
                        report_mismatch($sformatf("site %0d skipped %b, want %b",
                                                  want.site_echo, record.skipped,
                                                  want.skipped));
                    n_checked++;
                    if (want.skipped)
                        n_skipped++;
                end
            end
            if (start && !busy)
                expected_records.push_back(predict_record(sample));
            pending <= expected_records.size();
            errors <= fail_count;
            checked <= n_checked;
            skipped_total <= n_skipped;
        end
    end

endmodule

>>> sim/float_exponent_range_profiler_test.sv
// Testbench top for the exponent range profiler: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module float_exponent_range_profiler_test;
    import ferp_pkg::*;

    localparam int RANDOM_ITEMS   = 1800;
    localparam int WATCHDOG_LIMIT = 500;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_item_t  sample = '0;
    wire       busy;
    wire       done;
    out_item_t record;

    int errors;
    int pending;
    int checked;
    int skipped_total;
    int items_sent = 0;
    int idle_cycles = 0;

    logic [SITE_W-1:0] hot_sites [8];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    float_exponent_range_profiler u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .sample (sample),
        .done   (done),
        .record (record)
    );

    ferp_record_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .sample        (sample),
        .done          (done),
        .record        (record),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked),
        .skipped_total (skipped_total)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // random raw bits with the format's exponent and sign forced
    function automatic in_item_t make_sample(input logic [1:0] f, input logic [SITE_W-1:0] s,
                                             input logic [EXP_W-1:0] e, input logic sg);
        in_item_t it;
        it.fmt = f;
        it.site = s;
        it.raw_bits = {$urandom, $urandom};
        case (f)
            FMT_HALF:
            begin
                it.raw_bits[HALF_EXP_LSB +: HALF_EXP_W] = e[HALF_EXP_W-1:0];
                it.raw_bits[HALF_SIGN] = sg;
            end
            FMT_SINGLE:
            begin
                it.raw_bits[SINGLE_EXP_LSB +: SINGLE_EXP_W] = e[SINGLE_EXP_W-1:0];
                it.raw_bits[SINGLE_SIGN] = sg;
            end
            FMT_DOUBLE:
            begin
                it.raw_bits[DOUBLE_EXP_LSB +: DOUBLE_EXP_W] = e;
                it.raw_bits[DOUBLE_SIGN] = sg;
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_sample(input in_item_t s, input int gap);
        start <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            sample <= in_item_t'{2'($urandom), SITE_W'($urandom), {$urandom, $urandom}};
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_records();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        logic [1:0]        f;
        logic [SITE_W-1:0] s;
        logic [EXP_W-1:0]  e;
        int                emax;
        int                kind;
        int                gap;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items, back to back but for one gap
        send_sample(make_sample(FMT_HALF, 8'd0, 11'd1, 1'b0), 0);
        send_sample(make_sample(FMT_HALF, 8'd0, 11'd31, 1'b1), 0);
        send_sample(make_sample(FMT_HALF, 8'd0, 11'd0, 1'b1), 0);
        send_sample(make_sample(FMT_BAD, 8'd1, 11'd5, 1'b1), 0);
        send_sample(make_sample(FMT_SINGLE, 8'd1, 11'd128, 1'b0), 0);
        send_sample(make_sample(FMT_SINGLE, 8'd1, 11'd1, 1'b0), 0);
        send_sample(make_sample(FMT_SINGLE, 8'd1, 11'd255, 1'b0), 0);
        send_sample(make_sample(FMT_DOUBLE, 8'd2, 11'd2047, 1'b1), 0);
        send_sample(make_sample(FMT_DOUBLE, 8'd2, 11'd1, 1'b0), 0);
        send_sample(make_sample(FMT_DOUBLE, 8'd2, 11'd0, 1'b0), 0);
        send_sample(make_sample(FMT_DOUBLE, 8'd255, 11'd1024, 1'b0), 0);
        send_sample(make_sample(FMT_HALF, 8'd255, 11'd16, 1'b0), 0);
        send_sample(make_sample(FMT_BAD, 8'd255, 11'd0, 1'b0), 0);
        send_sample(make_sample(FMT_SINGLE, 8'd254, 11'd0, 1'b1), 0);
        send_sample(in_item_t'{FMT_DOUBLE, 8'd3, {RAW_W{1'b1}}}, 0);
        send_sample(in_item_t'{FMT_HALF, 8'd3, {RAW_W{1'b1}}}, 0);
        send_sample(in_item_t'{FMT_SINGLE, 8'd4, {RAW_W{1'b0}}}, 0);
        send_sample(in_item_t'{FMT_BAD, 8'd128, {RAW_W{1'b1}}}, 0);
        send_sample(make_sample(FMT_DOUBLE, 8'd0, 11'd1000, 1'b0), 3);
        send_sample(make_sample(FMT_SINGLE, 8'd0, 11'd200, 1'b1), 0);
        drain_records();

        for (int i = 0; i < 8; i++)
            hot_sites[i] = SITE_W'($urandom_range(0, SITES - 1));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 400 == 399)
                drain_records();
            f = ($urandom_range(0, 9) == 0) ? FMT_BAD : 2'($urandom_range(1, 3));
            case (f)
                FMT_HALF:   emax = (1 << HALF_EXP_W) - 1;
                FMT_SINGLE: emax = (1 << SINGLE_EXP_W) - 1;
                default:    emax = (1 << DOUBLE_EXP_W) - 1;
            endcase
            kind = $urandom_range(0, 9);
            if (kind == 0)
                e = '0;
            else if (kind == 1)
                e = 11'd1;
            else if (kind == 2)
                e = EXP_W'(emax);
            else
                e = EXP_W'($urandom_range(0, emax));
            if ($urandom_range(0, 3) != 0)
                s = hot_sites[3'($urandom_range(0, 7))];
            else
                s = SITE_W'($urandom_range(0, SITES - 1));
            // odd phases run with no gaps, apart from the drain before every 400th item
            if ((n / 150) % 2 == 1)
                gap = 0;
            else
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
            send_sample(make_sample(f, s, e, 1'($urandom_range(0, 1))), gap);
        end

        drain_records();
        repeat (10) @(posedge clk);

        $display("Sent %0d items across all formats and unknown codes, hot and scattered sites.",
                 items_sent);
        $display("Checked %0d records, %0d of them for skipped samples.",
                 checked, skipped_total);
        if (pending != 0)
            $display("%0d records never arrived", pending);
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
hdl/ferp_pkg.sv
hdl/ferp_extract.sv
hdl/ferp_table.sv
hdl/float_exponent_range_profiler.sv
hdl/ferp_checker.sv
sim/ferp_record_checker.sv
sim/float_exponent_range_profiler_test.sv
